// File: hw/rtl/hmbs_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler package
// Widths, request kinds and defaults shared by the sampler modules.
// ----------------------------------------------------------------------------
package hmbs_pkg;

	localparam int GRID_SIZE_DEF = 256;

	localparam int ADDR_W   = 16;
	localparam int HEIGHT_W = 16;
	localparam int POS_W    = 17;
	localparam int FRAC_W   = 8;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 16;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

// File: hw/rtl/hmbs_axis.sv
// ----------------------------------------------------------------------------
// Heightmap sampler axis mapper
// Maps one signed Q9.8 world coordinate to a clamped Q.8 grid coordinate,
// floor(((pos + N/2) * (N-1)) / N), with an out-of-grid flag. The division
// by N is a reciprocal multiply with one correction step; three stages.
// ----------------------------------------------------------------------------
module hmbs_axis #(
	parameter int GRID_SIZE = hmbs_pkg::GRID_SIZE_DEF
) (
	input  logic                                             clk,
	input  logic signed [hmbs_pkg::POS_W-1:0]                pos,
	output logic [$clog2(GRID_SIZE)+hmbs_pkg::FRAC_W-1:0]    u,
	output logic                                             oor
);
	import hmbs_pkg::*;

	localparam int IW        = $clog2(GRID_SIZE);
	localparam int UOW       = IW + FRAC_W;
	localparam int FW        = POS_W + 3;
	localparam int WW        = POS_W + 3;
	localparam int UW        = POS_W + 5;
	localparam int SHIFT     = WW;
	localparam int RECIP     = (1 << SHIFT) / GRID_SIZE;
	localparam int MW        = $clog2(RECIP + 1);
	localparam int QW        = WW + MW - SHIFT;
	localparam int NW        = $clog2(GRID_SIZE + 1);
	localparam int HALF_OFS  = GRID_SIZE * 128;
	localparam int POS_MAX   = (1 << (POS_W - 1)) - 1;
	localparam int BIAS      = (POS_MAX + HALF_OFS) / GRID_SIZE + 1;
	localparam int BIAS_N    = BIAS * GRID_SIZE;
	localparam int TOP       = (GRID_SIZE - 1) * 256;

	localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
	localparam logic [NW-1:0] N_C     = NW'(GRID_SIZE);

	logic signed [FW-1:0]    f;
	logic [WW-1:0]           w;
	logic signed [FW-1:0]    f_s1;
	logic [WW-1:0]           w_s1;
	logic [WW+MW-1:0]        prod_s1;
	logic [QW-1:0]           qe;
	logic signed [FW-1:0]    f_s2;
	logic [WW-1:0]           w_s2;
	logic [QW-1:0]           qe_s2;
	logic [QW+NW-1:0]        qn_s2;
	logic [WW-1:0]           r;
	logic [QW:0]             qc;
	logic signed [UW-1:0]    uf;
	logic                    lo;
	logic                    hi;

	// shift by half the grid, then bias so the negated value stays non-negative
	always_comb begin
		f = FW'(pos) + FW'(HALF_OFS);
		w = WW'(FW'(BIAS_N) - f);
	end

	always_comb begin
		qe = prod_s1[WW+MW-1:SHIFT];
	end

	always_comb begin
		r  = w_s2 - WW'(qn_s2);
		qc = (QW+1)'(qe_s2) + (QW+1)'(r >= WW'(GRID_SIZE));
		uf = UW'(f_s2) + UW'(qc) - UW'(BIAS);
		lo = uf < 0;
		hi = uf > TOP;
	end

	always_ff @(posedge clk) begin
		f_s1    <= f;
		w_s1    <= w;
		prod_s1 <= {{MW{1'b0}}, w} * {{WW{1'b0}}, RECIP_C};
		f_s2    <= f_s1;
		w_s2    <= w_s1;
		qe_s2   <= qe;
		qn_s2   <= (QW+NW)'(qe) * (QW+NW)'(N_C);
		oor     <= lo | hi;
		if (lo) begin
			u <= '0;
		end else if (hi) begin
			u <= UOW'(TOP);
		end else begin
			u <= uf[UOW-1:0];
		end
	end

endmodule

// File: hw/rtl/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler
// Stores a square grid of Q8.8 heights and answers bilinear height queries
// at signed Q9.8 world positions, flagging positions outside the grid.
//
//   channel  dir  contents
//   s_*      in   request: write one height cell, or query a position
//   m_*      out  result: interpolated height and out-of-grid flag
//
// A write goes from accept straight to result; a query passes through accept,
// three mapping stages, four corner reads from the height memory (one read
// port), two blend steps, result. After reset a clearing pass zeroes all
// 65536 memory cells; no request is taken until it ends.
// A request is taken while the previous result still waits; a stalled
// result holds the block in its last step.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
	parameter int GRID_SIZE = hmbs_pkg::GRID_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// cell_index[15:0], height_value[31:16], pos_x[48:32], pos_z[65:49]
	input  logic [hmbs_pkg::S_TDATA_W-1:0]     s_tdata,
	// req_type[0]
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// height_out[15:0]
	output logic [hmbs_pkg::M_TDATA_W-1:0]     m_tdata,
	// out_of_range[0]
	output logic [0:0]                         m_tuser
);
	import hmbs_pkg::*;

	localparam int IW    = $clog2(GRID_SIZE);
	localparam int UOW   = IW + FRAC_W;
	localparam int DEPTH = 1 << ADDR_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP1,
		ST_MAP2,
		ST_MAP3,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_BL0,
		ST_BL1,
		ST_RESULT
	} state_t;

	state_t                     state_q;
	logic [ADDR_W-1:0]          clr_q;
	logic                       m_tvalid_q;
	logic [M_TDATA_W-1:0]       m_tdata_q;
	logic                       m_tuser_q;

	logic [HEIGHT_W-1:0]        mem [DEPTH];
	logic [HEIGHT_W-1:0]        rd_q;
	logic                       we;
	logic [ADDR_W-1:0]          wa;
	logic [HEIGHT_W-1:0]        wd;
	logic [ADDR_W-1:0]          ra;

	logic signed [POS_W-1:0]    pos_x_q;
	logic signed [POS_W-1:0]    pos_z_q;
	logic [UOW-1:0]             ux;
	logic [UOW-1:0]             uz;
	logic                       oorx;
	logic                       oorz;
	logic [IW-1:0]              x0;
	logic [IW-1:0]              x1;
	logic [IW-1:0]              z0;
	logic [IW-1:0]              z1;
	logic [FRAC_W-1:0]          tx;
	logic [FRAC_W-1:0]          tz;
	logic [IW-1:0]              xs;
	logic [IW-1:0]              zs;

	logic [HEIGHT_W-1:0]        h00_q;
	logic [HEIGHT_W-1:0]        h01_q;
	logic [HEIGHT_W-1:0]        h0_q;
	logic [HEIGHT_W-1:0]        h1_q;
	logic [HEIGHT_W-1:0]        res_q;
	logic                       res_oor_q;

	logic                       acc;
	logic                       out_free;

	function automatic logic [HEIGHT_W-1:0] lerp(
		input logic [HEIGHT_W-1:0] a,
		input logic [HEIGHT_W-1:0] b,
		input logic [FRAC_W-1:0]   t
	);
		logic [HEIGHT_W+FRAC_W:0] s;
		s = (HEIGHT_W+FRAC_W+1)'(a) * (HEIGHT_W+FRAC_W+1)'(9'd256 - 9'(t))
			+ (HEIGHT_W+FRAC_W+1)'(b) * (HEIGHT_W+FRAC_W+1)'(t);
		return s[HEIGHT_W+FRAC_W-1:FRAC_W];
	endfunction

	hmbs_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_x (
		.clk (clk),
		.pos (pos_x_q),
		.u   (ux),
		.oor (oorx)
	);

	hmbs_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_z (
		.clk (clk),
		.pos (pos_z_q),
		.u   (uz),
		.oor (oorz)
	);

	assign s_tready = state_q == ST_IDLE;
	assign acc      = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		x0 = ux[UOW-1:FRAC_W];
		z0 = uz[UOW-1:FRAC_W];
		tx = ux[FRAC_W-1:0];
		tz = uz[FRAC_W-1:0];
		x1 = (x0 == IW'(GRID_SIZE - 1)) ? x0 : x0 + 1'b1;
		z1 = (z0 == IW'(GRID_SIZE - 1)) ? z0 : z0 + 1'b1;
	end

	// corner order: (x0,z0), (x1,z0), (x0,z1), (x1,z1)
	always_comb begin
		case (state_q)
			ST_RD1: begin
				xs = x1;
				zs = z0;
			end
			ST_RD2: begin
				xs = x0;
				zs = z1;
			end
			ST_RD3: begin
				xs = x1;
				zs = z1;
			end
			default: begin
				xs = x0;
				zs = z0;
			end
		endcase
		ra = ADDR_W'(32'(zs) * 32'(GRID_SIZE) + 32'(xs));
	end

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (acc && s_tuser[0] == REQ_WRITE) begin
			we = 1'b1;
			wa = s_tdata[15:0];
			wd = s_tdata[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_x_q <= s_tdata[48:32];
			pos_z_q <= s_tdata[65:49];
		end
		case (state_q)
			ST_IDLE: begin
				res_q     <= '0;
				res_oor_q <= 1'b0;
			end
			ST_RD1:  h00_q <= rd_q;
			ST_RD2:  h0_q  <= lerp(h00_q, rd_q, tx);
			ST_RD3:  h01_q <= rd_q;
			ST_BL0:  h1_q  <= lerp(h01_q, rd_q, tx);
			ST_BL1: begin
				res_q     <= lerp(h0_q, h1_q, tz);
				res_oor_q <= oorx | oorz;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_RESULT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= (s_tuser[0] == REQ_QUERY) ? ST_MAP1 : ST_RESULT;
					end
				end
				ST_MAP1: state_q <= ST_MAP2;
				ST_MAP2: state_q <= ST_MAP3;
				ST_MAP3: state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_BL0;
				ST_BL0:  state_q <= ST_BL1;
				ST_BL1:  state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tuser_q  <= res_oor_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
